// ----- sv/drflt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, types and date helpers for the dated rate floor table.
// Used by every module of the block; depends on nothing else.

package drflt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 7;
    localparam int DAY_W       = 7;
    localparam int KEY_W       = 23;
    localparam int RATE_W      = 31;
    localparam int AMOUNT_W    = 32;
    localparam int PRODUCT_W   = 63;
    localparam int STATUS_W    = 3;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 64;
    localparam int GROUP_SIZE  = 16;
    localparam int NUM_GROUPS  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_DEPTH   = NUM_GROUPS * GROUP_SIZE;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_DATE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NEG_AMOUNT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_EARLIER = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NEG_RATE   = 3'd6;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [AMOUNT_W-1:0] AMOUNT_LIMIT = 32'd65536000;
    localparam logic [YEAR_W-1:0]   MAX_YEAR     = 14'd9999;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  date;
        logic [RATE_W-1:0] rate;
    } cell_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              cmp;
        logic              ins;
        logic              ovw;
        logic [KEY_W-1:0]  key;
        logic [RATE_W-1:0] rate;
    } ctl_t;

    typedef struct packed {
        logic              hit;
        logic              eq;
        logic [RATE_W-1:0] rate;
    } grp_t;

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        begin
            case (m)
                4'd2:    n = leap ? 5'd29 : 5'd28;
                4'd4:    n = 5'd30;
                4'd6:    n = 5'd30;
                4'd9:    n = 5'd30;
                4'd11:   n = 5'd30;
                default: n = 5'd31;
            endcase
            return n;
        end
    endfunction

    // Gregorian check; y / 100 by reciprocal multiply, exact for 14-bit years.
    function automatic logic date_valid(input logic [YEAR_W-1:0] y,
                                        input logic [MONTH_W-1:0] m,
                                        input logic [DAY_W-1:0] d);
        logic [26:0] recip;
        logic [7:0]  q;
        logic [14:0] hund;
        logic [13:0] rem;
        logic        leap;
        logic        ok;
        begin
            recip = {13'd0, y} * 27'd5243;
            q     = recip[26:19];
            hund  = {7'd0, q} * 15'd100;
            rem   = y - hund[13:0];
            leap  = ((y[1:0] == 2'd0) && (rem != 14'd0))
                  || ((rem == 14'd0) && (y[3:0] == 4'd0));
            ok = (y <= MAX_YEAR) && (m >= 7'd1) && (m <= 7'd12) && (d >= 7'd1);
            if (ok)
            begin
                ok = (d <= {2'd0, month_days(m[3:0], leap)});
            end
            return ok;
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/drflt_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// One table slot: holds a dated rate, compares it against the broadcast key
// and shifts from its lower neighbor on insert. Depends on drflt_pkg.

module drflt_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire drflt_pkg::ctl_t  ctl,
    input  wire drflt_pkg::cell_t prev_data,
    input  wire logic            prev_lt,
    input  wire logic            next_lt,
    input  wire logic            next_eq,
    output drflt_pkg::cell_t     data,
    output logic                 lt,
    output logic                 eq,
    output logic                 sel
);

    logic                          valid_reg, valid_next;
    logic [drflt_pkg::KEY_W-1:0]   date_reg, date_next;
    logic [drflt_pkg::RATE_W-1:0]  rate_reg, rate_next;
    logic                          lt_reg, lt_next;
    logic                          eq_reg, eq_next;

    always_comb
    begin
        valid_next = valid_reg;
        date_next  = date_reg;
        rate_next  = rate_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        if (ctl.cmp)
        begin
            lt_next = valid_reg && (date_reg < ctl.key);
            eq_next = valid_reg && (date_reg == ctl.key);
        end
        if (ctl.ovw && eq_reg)
        begin
            rate_next = ctl.rate;
        end
        if (ctl.ins && !lt_reg)
        begin
            if (prev_lt)
            begin
                valid_next = 1'b1;
                date_next  = ctl.key;
                rate_next  = ctl.rate;
            end
            else
            begin
                // advance the entry one slot up
                valid_next = prev_data.valid;
                date_next  = prev_data.date;
                rate_next  = prev_data.rate;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        date_reg <= date_next;
        rate_reg <= rate_next;
    end

    assign data.valid = valid_reg;
    assign data.date  = date_reg;
    assign data.rate  = rate_reg;
    assign lt         = lt_reg;
    assign eq         = eq_reg;
    // floor slot: exact match, or last entry below the key
    assign sel        = eq_reg || (lt_reg && !next_lt && !next_eq);

endmodule

`default_nettype wire

// ----- sv/drflt_group.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Registered reduction of one group of cells: floor rate and match flags.
// Depends on drflt_pkg.

module drflt_group (
    input  wire logic                                            clk,
    input  wire logic [drflt_pkg::GROUP_SIZE-1:0]                sel,
    input  wire logic [drflt_pkg::GROUP_SIZE-1:0]                eq,
    input  wire logic [drflt_pkg::GROUP_SIZE-1:0][drflt_pkg::RATE_W-1:0] rate,
    output drflt_pkg::grp_t                                      grp
);

    logic [drflt_pkg::RATE_W-1:0] rate_reg, rate_next;
    logic                         hit_reg, hit_next;
    logic                         eq_reg, eq_next;

    always_comb
    begin
        rate_next = '0;
        for (int i = 0; i < drflt_pkg::GROUP_SIZE; i++)
        begin
            rate_next = rate_next | (rate[i] & {drflt_pkg::RATE_W{sel[i]}});
        end
        hit_next = |sel;
        eq_next  = |eq;
    end

    always_ff @(posedge clk)
    begin
        rate_reg <= rate_next;
        hit_reg  <= hit_next;
        eq_reg   <= eq_next;
    end

    assign grp.rate = rate_reg;
    assign grp.hit  = hit_reg;
    assign grp.eq   = eq_reg;

endmodule

`default_nettype wire

// ----- sv/dated_rate_floor_lookup_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level of the dated rate floor table: sequencer, row of cells, group
// reduction and output register. Depends on drflt_pkg, drflt_cell, drflt_group.
//
//  channel | direction | tdata (low bit up)                     | tuser
//  s_axis  | in        | year 14, month 7, day 7, amount 32, pad | op
//  m_axis  | out       | product 63, pad                         | status 3
//
// An item goes in order through accept, compare in every cell, group reduce,
// decide and update the cells, multiply into the output register.
// Reset clears every cell's valid bit at once; the table is empty after reset.
// A new beat is taken while a result waits; the multiply step holds until
// the output register is free.

module dated_rate_floor_lookup_table_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [drflt_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // year, month, day, amount
    input  wire logic                                s_axis_tuser,  // op
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [drflt_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // product
    output logic [drflt_pkg::STATUS_W-1:0]           m_axis_tuser   // status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_RED  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic                             op_reg;
    logic [drflt_pkg::YEAR_W-1:0]     year_reg;
    logic [drflt_pkg::MONTH_W-1:0]    month_reg;
    logic [drflt_pkg::DAY_W-1:0]      day_reg;
    logic [drflt_pkg::AMOUNT_W-1:0]   amount_reg;
    logic                             date_ok_reg;
    logic [drflt_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [drflt_pkg::RATE_W-1:0]     rate_op_reg, rate_op_next;
    logic                             out_valid_reg, out_valid_next;
    logic [drflt_pkg::STATUS_W-1:0]   out_status_reg;
    logic [drflt_pkg::PRODUCT_W-1:0]  out_product_reg;

    drflt_pkg::ctl_t                  ctl;
    drflt_pkg::cell_t                 cell_data [drflt_pkg::TABLE_DEPTH];
    logic [drflt_pkg::TABLE_DEPTH-1:0] lt, eq, sel;
    logic [drflt_pkg::PAD_DEPTH-1:0]  sel_pad, eq_pad;
    logic [drflt_pkg::PAD_DEPTH-1:0][drflt_pkg::RATE_W-1:0] rate_pad;
    drflt_pkg::grp_t                  grp [drflt_pkg::NUM_GROUPS];

    logic                             in_beat;
    logic                             out_free;
    logic                             any_eq;
    logic [drflt_pkg::RATE_W-1:0]     found_rate;
    logic                             neg;
    logic                             full;
    logic                             has_floor;
    logic [61:0]                      mul_full;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign neg      = amount_reg[drflt_pkg::AMOUNT_W-1];
    assign full     = cell_data[drflt_pkg::TABLE_DEPTH-1].valid;
    assign has_floor = lt[0] || eq[0];

    assign s_axis_tready = (state_reg == S_IDLE);

    // cell row
    for (genvar i = 0; i < drflt_pkg::TABLE_DEPTH; i++)
    begin : g_cell
        drflt_pkg::cell_t prev_d;
        logic             prev_l;
        logic             next_l;
        logic             next_e;
        if (i == 0)
        begin : g_first
            assign prev_d = '0;
            assign prev_l = 1'b1;
        end
        else
        begin : g_mid
            assign prev_d = cell_data[i-1];
            assign prev_l = lt[i-1];
        end
        if (i == drflt_pkg::TABLE_DEPTH - 1)
        begin : g_last
            assign next_l = 1'b0;
            assign next_e = 1'b0;
        end
        else
        begin : g_inner
            assign next_l = lt[i+1];
            assign next_e = eq[i+1];
        end
        drflt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .prev_data (prev_d),
            .prev_lt   (prev_l),
            .next_lt   (next_l),
            .next_eq   (next_e),
            .data      (cell_data[i]),
            .lt        (lt[i]),
            .eq        (eq[i]),
            .sel       (sel[i])
        );
    end

    always_comb
    begin
        sel_pad  = '0;
        eq_pad   = '0;
        rate_pad = '0;
        sel_pad[drflt_pkg::TABLE_DEPTH-1:0] = sel;
        eq_pad[drflt_pkg::TABLE_DEPTH-1:0]  = eq;
        for (int i = 0; i < drflt_pkg::TABLE_DEPTH; i++)
        begin
            rate_pad[i] = cell_data[i].rate;
        end
    end

    for (genvar g = 0; g < drflt_pkg::NUM_GROUPS; g++)
    begin : g_grp
        drflt_group u_group (
            .clk  (clk),
            .sel  (sel_pad[g*drflt_pkg::GROUP_SIZE +: drflt_pkg::GROUP_SIZE]),
            .eq   (eq_pad[g*drflt_pkg::GROUP_SIZE +: drflt_pkg::GROUP_SIZE]),
            .rate (rate_pad[g*drflt_pkg::GROUP_SIZE +: drflt_pkg::GROUP_SIZE]),
            .grp  (grp[g])
        );
    end

    always_comb
    begin
        any_eq     = 1'b0;
        found_rate = '0;
        for (int g = 0; g < drflt_pkg::NUM_GROUPS; g++)
        begin
            any_eq     = any_eq | grp[g].eq;
            found_rate = found_rate | grp[g].rate;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        status_next  = status_reg;
        rate_op_next = rate_op_reg;
        ctl.cmp      = 1'b0;
        ctl.ins      = 1'b0;
        ctl.ovw      = 1'b0;
        ctl.key      = {year_reg, month_reg[3:0], day_reg[4:0]};
        ctl.rate     = amount_reg[drflt_pkg::RATE_W-1:0];
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctl.cmp    = 1'b1;
                state_next = S_RED;
            end
            S_RED:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                status_next  = drflt_pkg::ST_OK;
                rate_op_next = '0;
                if (!date_ok_reg)
                begin
                    status_next = drflt_pkg::ST_BAD_DATE;
                end
                else if (op_reg == drflt_pkg::OP_INSERT)
                begin
                    if (neg)
                    begin
                        status_next = drflt_pkg::ST_NEG_RATE;
                    end
                    else if (any_eq)
                    begin
                        ctl.ovw = 1'b1;
                    end
                    else if (full)
                    begin
                        status_next = drflt_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.ins = 1'b1;
                    end
                end
                else
                begin
                    if (neg)
                    begin
                        status_next = drflt_pkg::ST_NEG_AMOUNT;
                    end
                    else if (amount_reg > drflt_pkg::AMOUNT_LIMIT)
                    begin
                        status_next = drflt_pkg::ST_TOO_LARGE;
                    end
                    else if (!has_floor)
                    begin
                        status_next = drflt_pkg::ST_NO_EARLIER;
                    end
                    else
                    begin
                        rate_op_next = found_rate;
                    end
                end
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // in the multiply step, amount is nonnegative whenever the rate operand is nonzero
    assign mul_full = amount_reg[drflt_pkg::RATE_W-1:0] * rate_op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            op_reg     <= s_axis_tuser;
            year_reg   <= s_axis_tdata[13:0];
            month_reg  <= s_axis_tdata[20:14];
            day_reg    <= s_axis_tdata[27:21];
            amount_reg <= s_axis_tdata[59:28];
        end
        if (state_reg == S_CMP)
        begin
            date_ok_reg <= drflt_pkg::date_valid(year_reg, month_reg, day_reg);
        end
        status_reg  <= status_next;
        rate_op_reg <= rate_op_next;
        if ((state_reg == S_MUL) && out_free)
        begin
            out_status_reg  <= status_reg;
            out_product_reg <= {1'b0, mul_full};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {1'b0, out_product_reg};

endmodule

`default_nettype wire

// ----- tb/tb_dated_rate_floor_lookup_table_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the dated rate floor table: directed rows, then
// random insert/query traffic with its own sorted-table predictor.
// Depends on drflt_pkg and the dated_rate_floor_lookup_table_unit RTL.

module tb_dated_rate_floor_lookup_table_unit;
    import drflt_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [PRODUCT_W-1:0] product;
    } rate_result_t;

    // Typed rows always expect a zero product.
    typedef struct packed {
        logic                 op;
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [AMOUNT_W-1:0]  amount;
        logic                 typed;
        logic [STATUS_W-1:0]  status;
    } rate_row_t;

    localparam int NUM_ROWS = 25;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // year 14, month 7, day 7, amount 32, pad
    logic                  s_axis_tuser;   // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // product 63, pad
    logic [STATUS_W-1:0]   m_axis_tuser;   // status

    // Predictor copy of the sorted table.
    logic [KEY_W-1:0]  rate_date [TABLE_DEPTH];
    logic [RATE_W-1:0] rate_val  [TABLE_DEPTH];
    int                rate_count;

    rate_result_t pending_results [$];
    int fail_count;
    int results_seen;
    int items_sent;
    int status_seen [8];
    int tx_calm;
    int rx_calm;
    bit long_hold_done;

    rate_row_t directed_rows [NUM_ROWS] = '{
        '{OP_QUERY,  14'd0,     7'd1,   7'd1,   32'h0001_0000, 1'b1, ST_NO_EARLIER},
        '{OP_INSERT, 14'd2000,  7'd2,   7'd29,  32'h0002_0000, 1'b1, ST_OK},
        '{OP_INSERT, 14'd1900,  7'd2,   7'd29,  32'h0001_0000, 1'b1, ST_BAD_DATE},
        '{OP_INSERT, 14'd2004,  7'd2,   7'd29,  32'h7FFF_FFFF, 1'b1, ST_OK},
        '{OP_INSERT, 14'd2001,  7'd2,   7'd29,  32'h0001_0000, 1'b1, ST_BAD_DATE},
        '{OP_INSERT, 14'd10000, 7'd1,   7'd1,   32'h0001_0000, 1'b1, ST_BAD_DATE},
        '{OP_INSERT, 14'd16383, 7'd127, 7'd127, 32'hFFFF_FFFF, 1'b1, ST_BAD_DATE},
        '{OP_INSERT, 14'd9999,  7'd12,  7'd31,  32'h0000_0000, 1'b1, ST_OK},
        '{OP_INSERT, 14'd2000,  7'd13,  7'd1,   32'h0001_0000, 1'b1, ST_BAD_DATE},
        '{OP_INSERT, 14'd2000,  7'd0,   7'd1,   32'h0001_0000, 1'b1, ST_BAD_DATE},
        '{OP_INSERT, 14'd2000,  7'd1,   7'd0,   32'h0001_0000, 1'b1, ST_BAD_DATE},
        '{OP_INSERT, 14'd2000,  7'd1,   7'd32,  32'h0001_0000, 1'b1, ST_BAD_DATE},
        '{OP_INSERT, 14'd2000,  7'd4,   7'd31,  32'h0001_0000, 1'b1, ST_BAD_DATE},
        '{OP_INSERT, 14'd2010,  7'd6,   7'd15,  32'h8000_0000, 1'b1, ST_NEG_RATE},
        '{OP_QUERY,  14'd2010,  7'd6,   7'd15,  32'hFFFF_FFFF, 1'b1, ST_NEG_AMOUNT},
        '{OP_QUERY,  14'd2010,  7'd6,   7'd15,  32'h03E8_0001, 1'b1, ST_TOO_LARGE},
        '{OP_QUERY,  14'd2000,  7'd2,   7'd30,  32'h8000_0000, 1'b1, ST_BAD_DATE},
        '{OP_QUERY,  14'd2004,  7'd2,   7'd29,  32'h03E8_0000, 1'b0, ST_OK},
        '{OP_QUERY,  14'd9999,  7'd12,  7'd31,  32'h03E8_0000, 1'b1, ST_OK},
        '{OP_QUERY,  14'd2004,  7'd3,   7'd1,   32'h0001_0000, 1'b0, ST_OK},
        '{OP_INSERT, 14'd2000,  7'd2,   7'd29,  32'h0003_0000, 1'b1, ST_OK},
        '{OP_QUERY,  14'd2003,  7'd12,  7'd31,  32'h0001_8000, 1'b0, ST_OK},
        '{OP_QUERY,  14'd2000,  7'd2,   7'd29,  32'h0000_0000, 1'b1, ST_OK},
        '{OP_QUERY,  14'd1999,  7'd12,  7'd31,  32'h0001_0000, 1'b1, ST_NO_EARLIER},
        '{OP_INSERT, 14'd1600,  7'd2,   7'd29,  32'h0001_0000, 1'b1, ST_OK}
    };

    dated_rate_floor_lookup_table_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int days_in_month(input int y, input int m);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            2:       return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic bit calendar_ok(input logic [YEAR_W-1:0] y,
                                       input logic [MONTH_W-1:0] m,
                                       input logic [DAY_W-1:0] d);
        if (y > 9999 || m < 1 || m > 12 || d < 1)
            return 1'b0;
        return d <= days_in_month(int'(y), int'(m));
    endfunction

    // Apply one item to the predictor table and work out its result.
    function automatic rate_result_t apply_rate_item(input logic op,
                                                     input logic [YEAR_W-1:0] y,
                                                     input logic [MONTH_W-1:0] m,
                                                     input logic [DAY_W-1:0] d,
                                                     input logic [AMOUNT_W-1:0] amt);
        rate_result_t res;
        logic [KEY_W-1:0] key;
        logic [63:0] wide;
        int pos;
        int pick;
        res = '0;
        pick = -1;
        if (!calendar_ok(y, m, d))
        begin
            res.status = ST_BAD_DATE;
            return res;
        end
        key = {y, m[3:0], d[4:0]};
        pos = 0;
        while (pos < rate_count && rate_date[pos] < key)
            pos++;
        if (op == OP_INSERT)
        begin
            if (amt[AMOUNT_W-1])
                res.status = ST_NEG_RATE;
            else if (pos < rate_count && rate_date[pos] == key)
                rate_val[pos] = amt[RATE_W-1:0];
            else if (rate_count >= TABLE_DEPTH)
                res.status = ST_FULL;
            else
            begin
                for (int j = rate_count; j > pos; j--)
                begin
                    rate_date[j] = rate_date[j-1];
                    rate_val[j]  = rate_val[j-1];
                end
                rate_date[pos] = key;
                rate_val[pos]  = amt[RATE_W-1:0];
                rate_count++;
            end
        end
        else
        begin
            if (amt[AMOUNT_W-1])
                res.status = ST_NEG_AMOUNT;
            else if (amt > AMOUNT_LIMIT)
                res.status = ST_TOO_LARGE;
            else if (pos < rate_count && rate_date[pos] == key)
                pick = pos;
            else if (pos == 0)
                res.status = ST_NO_EARLIER;
            else
                pick = pos - 1;
            if (pick >= 0)
            begin
                wide = 64'(amt) * 64'(rate_val[pick]);
                res.product = wide[63] ? {PRODUCT_W{1'b1}} : wide[PRODUCT_W-1:0];
            end
        end
        return res;
    endfunction

    // Mostly busy with random gaps; now and then a run of back-to-back beats.
    function automatic int pick_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    task automatic offer_rate_item(input logic op, input logic [YEAR_W-1:0] y,
                                   input logic [MONTH_W-1:0] m,
                                   input logic [DAY_W-1:0] d,
                                   input logic [AMOUNT_W-1:0] amt,
                                   input bit typed, input logic [STATUS_W-1:0] st);
        int gap;
        rate_result_t res;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, amt, d, m, y};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = apply_rate_item(op, y, m, d, amt);
        if (typed)
        begin
            res.status  = st;
            res.product = '0;
        end
        pending_results.push_back(res);
        items_sent++;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_failure(input string what, input rate_result_t want,
                                input rate_result_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected status %0d product %h, got status %0d product %h",
                     $realtime, what, want.status, want.product, got.status, got.product);
    endtask

    task automatic offer_random_item(input int insert_pct, input bit wide_years);
        logic op;
        logic [YEAR_W-1:0] y;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0] d;
        logic [AMOUNT_W-1:0] amt;
        int r;
        op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_QUERY;
        if ($urandom_range(0, 99) < 8)
        begin
            // noise: any bit pattern of every field
            y   = YEAR_W'($urandom_range(0, 16383));
            m   = MONTH_W'($urandom_range(0, 127));
            d   = DAY_W'($urandom_range(0, 127));
            amt = $urandom();
        end
        else
        begin
            y = (wide_years || $urandom_range(0, 4) == 0) ? YEAR_W'($urandom_range(0, 9999))
                                                          : YEAR_W'($urandom_range(1995, 2025));
            m = MONTH_W'($urandom_range(1, 12));
            d = DAY_W'($urandom_range(1, days_in_month(int'(y), int'(m))));
            r = $urandom_range(0, 99);
            if (op == OP_INSERT)
            begin
                if (r < 5)
                    amt = $urandom() | 32'h8000_0000;
                else if (r < 8)
                    amt = 32'h7FFF_FFFF;
                else if (r < 11)
                    amt = '0;
                else
                    amt = $urandom_range(0, 32'h7FFF_FFFF);
            end
            else
            begin
                if (r < 5)
                    amt = $urandom() | 32'h8000_0000;
                else if (r < 10)
                    amt = $urandom_range(AMOUNT_LIMIT + 1, 32'h7FFF_FFFF);
                else if (r < 15)
                    amt = AMOUNT_LIMIT;
                else if (r < 18)
                    amt = '0;
                else
                    amt = $urandom_range(0, AMOUNT_LIMIT);
            end
        end
        offer_rate_item(op, y, m, d, amt, 1'b0, ST_OK);
    endtask

    // Result side: random stall before each beat, one long hold to back up the block.
    initial
    begin : result_side
        int gap;
        rate_result_t got;
        rate_result_t want;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = pick_gap(rx_calm);
            if (!long_hold_done && results_seen >= 200)
            begin
                long_hold_done = 1'b1;
                gap = 400;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            got.status  = m_axis_tuser;
            got.product = m_axis_tdata[PRODUCT_W-1:0];
            results_seen++;
            status_seen[got.status]++;
            if (pending_results.size() == 0)
                note_failure("result with nothing pending", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.product != want.product)
                    note_failure("mismatch", want, got);
            end
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("tb_dated_rate_floor_lookup_table_unit NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        int guard;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_INSERT;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_rate_item(directed_rows[i].op, directed_rows[i].year,
                            directed_rows[i].month, directed_rows[i].day,
                            directed_rows[i].amount, directed_rows[i].typed,
                            directed_rows[i].status);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Partly filled table, dates clustered so floors and overwrites are common.
        repeat (800)
            offer_random_item(25, 1'b0);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Fill the table with new dates spread over all years.
        guard = 0;
        while (rate_count < TABLE_DEPTH && guard < 2000)
        begin
            offer_random_item(100, 1'b1);
            guard++;
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // Full table: new dates are refused, overwrites and lookups still go.
        repeat (1100)
            offer_random_item(40, $urandom_range(0, 1));
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            fail_count++;
            $display("%0d results still pending", pending_results.size());
        end
        $display("%0d items, %0d results, %0d table entries at the end",
                 items_sent, results_seen, rate_count);
        $display("status counts ok %0d date %0d neg %0d big %0d none %0d full %0d rate %0d",
                 status_seen[ST_OK], status_seen[ST_BAD_DATE], status_seen[ST_NEG_AMOUNT],
                 status_seen[ST_TOO_LARGE], status_seen[ST_NO_EARLIER], status_seen[ST_FULL],
                 status_seen[ST_NEG_RATE]);
        if (fail_count == 0)
            $display("tb_dated_rate_floor_lookup_table_unit OK");
        else
            $display("tb_dated_rate_floor_lookup_table_unit NOT OK");
        $finish;
    end

endmodule
